FILE: design/ttuv_pkg.sv
// shared types and constants for the triangle tangent block
package ttuv_pkg;

	localparam int QUOT_W = 32;
	localparam int OUT_W = 32;
	localparam int FRAC_BASE = 28;

	localparam logic [OUT_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] NEG_LIMIT = 32'h8000_0000;
	localparam logic [OUT_W-1:0] ONE_Q16 = 32'h0001_0000;

	localparam logic [1:0] FIRST_CORNER = 2'd0;
	localparam logic [1:0] LAST_CORNER = 2'd2;
	localparam logic [1:0] LAST_COMP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DET_A,
		ST_DET_B,
		ST_DET_C,
		ST_NUM_A,
		ST_NUM_B,
		ST_NUM_C,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_DU1_DV2,
		MUL_DU2_DV1,
		MUL_DV2_E1,
		MUL_DV1_E2
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic acc_load;
		logic det_load;
		logic div_start;
		logic out_load;
	} seq_ctl_t;

	typedef struct packed {
		logic start;
		logic neg;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [OUT_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: design/triangle_tangent_from_uv_top.sv
// triangle tangent from uv: corner capture, sequencer and shared datapath
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  in      | in_valid  | in_stall  | pos_x pos_y pos_z tex_u tex_v (one corner)
//  out     | out_valid | out_stall | tangent_x tangent_y tangent_z degenerate
//
// corners one and two of a triangle are taken while the sequencer is idle, with no stall
// the third corner holds the block: the determinant states DET_A, DET_B, DET_C, then
//   per component the multiply/subtract states NUM_A to NUM_C and the radix-2 divider
//   (32 quotient bits, one per cycle, plus start and finish); a zero determinant goes
//   straight from DET_C to DONE, and DONE waits until the output register is free
// reset clears the corner count, the sequencer and the output valid
// a stalled result sits in the output register while the next triangle's corners come in
module triangle_tangent_from_uv_top #(
	parameter int POSITION_WIDTH = 32,
	parameter int TEXCOORD_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,

	input logic in_valid,
	output logic in_stall,
	input logic signed [POSITION_WIDTH-1:0] pos_x,
	input logic signed [POSITION_WIDTH-1:0] pos_y,
	input logic signed [POSITION_WIDTH-1:0] pos_z,
	input logic signed [TEXCOORD_WIDTH-1:0] tex_u,
	input logic signed [TEXCOORD_WIDTH-1:0] tex_v,

	output logic out_valid,
	input logic out_stall,
	output logic signed [ttuv_pkg::OUT_W-1:0] tangent_x,
	output logic signed [ttuv_pkg::OUT_W-1:0] tangent_y,
	output logic signed [ttuv_pkg::OUT_W-1:0] tangent_z,
	output logic degenerate
);

	// edge and uv delta widths
	localparam int EW = POSITION_WIDTH + 1;
	localparam int DVW = TEXCOORD_WIDTH + 1;
	// multiplier operand b covers both an edge and a uv delta
	localparam int BW = (EW > DVW) ? EW : DVW;
	localparam int PW = DVW + BW;
	localparam int AW = PW + 1;
	// numerator and determinant widths
	localparam int NW = EW + DVW + 1;
	localparam int DW = 2 * DVW + 1;
	// fraction alignment: positive moves the numerator up, negative the divisor
	localparam int FRAC_SHIFT = ttuv_pkg::FRAC_BASE + TEXCOORD_WIDTH - POSITION_WIDTH;
	localparam int NS = (FRAC_SHIFT > 0) ? FRAC_SHIFT : 0;
	localparam int DS = (FRAC_SHIFT < 0) ? -FRAC_SHIFT : 0;
	localparam int NMW = NW + NS;
	localparam int DMW = DW + DS;
	localparam int OW = ttuv_pkg::OUT_W;

	ttuv_pkg::state_t state_q;
	ttuv_pkg::state_t state_d;
	ttuv_pkg::seq_ctl_t ctl;

	logic in_acc_w;
	logic third_w;
	logic out_free_w;

	// held corners
	logic [1:0] corner_q;
	logic signed [POSITION_WIDTH-1:0] p0_q [3];
	logic signed [POSITION_WIDTH-1:0] p1_q [3];
	logic signed [TEXCOORD_WIDTH-1:0] u0_q;
	logic signed [TEXCOORD_WIDTH-1:0] v0_q;
	logic signed [TEXCOORD_WIDTH-1:0] u1_q;
	logic signed [TEXCOORD_WIDTH-1:0] v1_q;
	logic signed [POSITION_WIDTH-1:0] pos_in_w [3];

	// triangle deltas, formed as the third corner comes in
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [DVW-1:0] du1_q;
	logic signed [DVW-1:0] dv1_q;
	logic signed [DVW-1:0] du2_q;
	logic signed [DVW-1:0] dv2_q;

	// shared multiplier and accumulate path
	logic signed [DVW-1:0] mul_a_w;
	logic signed [BW-1:0] mul_b_w;
	logic signed [PW-1:0] prod_w;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] diff_w;
	logic signed [DW-1:0] det_w;
	logic signed [DW-1:0] det_q;
	logic det_zero_w;
	logic [NW-1:0] num_w;
	logic [NW-1:0] num_mag_w;
	logic [DW-1:0] det_mag_w;
	logic [NMW-1:0] num_sh_w;
	logic [DMW-1:0] den_sh_w;

	ttuv_pkg::div_req_t div_req;
	ttuv_pkg::div_rsp_t div_rsp;

	// per-component results
	logic [1:0] comp_q;
	logic [OW-1:0] tan_q [3];
	logic degen_q;

	logic out_valid_q;
	logic [OW-1:0] tx_q;
	logic [OW-1:0] ty_q;
	logic [OW-1:0] tz_q;
	logic degenerate_q;

	assign in_stall = (state_q != ttuv_pkg::ST_IDLE);
	assign in_acc_w = in_valid && !in_stall;
	assign third_w = (corner_q == ttuv_pkg::LAST_CORNER);
	assign out_free_w = !out_valid_q || !out_stall;

	assign pos_in_w[0] = pos_x;
	assign pos_in_w[1] = pos_y;
	assign pos_in_w[2] = pos_z;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttuv_pkg::ST_IDLE: begin
				if (in_acc_w && third_w) begin
					state_d = ttuv_pkg::ST_DET_A;
				end
			end
			ttuv_pkg::ST_DET_A: state_d = ttuv_pkg::ST_DET_B;
			ttuv_pkg::ST_DET_B: state_d = ttuv_pkg::ST_DET_C;
			ttuv_pkg::ST_DET_C: begin
				state_d = det_zero_w ? ttuv_pkg::ST_DONE : ttuv_pkg::ST_NUM_A;
			end
			ttuv_pkg::ST_NUM_A: state_d = ttuv_pkg::ST_NUM_B;
			ttuv_pkg::ST_NUM_B: state_d = ttuv_pkg::ST_NUM_C;
			ttuv_pkg::ST_NUM_C: state_d = ttuv_pkg::ST_DIV;
			ttuv_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = (comp_q == ttuv_pkg::LAST_COMP) ?
						ttuv_pkg::ST_DONE : ttuv_pkg::ST_NUM_A;
				end
			end
			ttuv_pkg::ST_DONE: begin
				if (out_free_w) begin
					state_d = ttuv_pkg::ST_IDLE;
				end
			end
			default: state_d = ttuv_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		ctl.mul_sel = ttuv_pkg::MUL_DU1_DV2;
		unique case (state_q)
			ttuv_pkg::ST_DET_A: ctl.mul_sel = ttuv_pkg::MUL_DU1_DV2;
			ttuv_pkg::ST_DET_B: begin
				ctl.mul_sel = ttuv_pkg::MUL_DU2_DV1;
				ctl.acc_load = 1'b1;
			end
			ttuv_pkg::ST_DET_C: ctl.det_load = 1'b1;
			ttuv_pkg::ST_NUM_A: ctl.mul_sel = ttuv_pkg::MUL_DV2_E1;
			ttuv_pkg::ST_NUM_B: begin
				ctl.mul_sel = ttuv_pkg::MUL_DV1_E2;
				ctl.acc_load = 1'b1;
			end
			ttuv_pkg::ST_NUM_C: ctl.div_start = 1'b1;
			ttuv_pkg::ST_DONE: ctl.out_load = out_free_w;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttuv_pkg::ST_IDLE;
			corner_q <= ttuv_pkg::FIRST_CORNER;
			comp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc_w) begin
				corner_q <= third_w ? ttuv_pkg::FIRST_CORNER : corner_q + 1'b1;
			end
			if (ctl.det_load) begin
				comp_q <= '0;
			end else if (state_q == ttuv_pkg::ST_DIV && div_rsp.done) begin
				comp_q <= comp_q + 1'b1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// corner capture and deltas
	always_ff @(posedge clk) begin
		if (in_acc_w) begin
			if (corner_q == ttuv_pkg::FIRST_CORNER) begin
				for (int k = 0; k < 3; k++) begin
					p0_q[k] <= pos_in_w[k];
				end
				u0_q <= tex_u;
				v0_q <= tex_v;
			end else if (!third_w) begin
				for (int k = 0; k < 3; k++) begin
					p1_q[k] <= pos_in_w[k];
				end
				u1_q <= tex_u;
				v1_q <= tex_v;
			end else begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= EW'(p1_q[k]) - EW'(p0_q[k]);
					e2_q[k] <= EW'(pos_in_w[k]) - EW'(p0_q[k]);
				end
				du1_q <= DVW'(u1_q) - DVW'(u0_q);
				dv1_q <= DVW'(v1_q) - DVW'(v0_q);
				du2_q <= DVW'(tex_u) - DVW'(u0_q);
				dv2_q <= DVW'(tex_v) - DVW'(v0_q);
			end
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (ctl.mul_sel)
			ttuv_pkg::MUL_DU1_DV2: begin
				mul_a_w = du1_q;
				mul_b_w = BW'(dv2_q);
			end
			ttuv_pkg::MUL_DU2_DV1: begin
				mul_a_w = dv1_q;
				mul_b_w = BW'(du2_q);
			end
			ttuv_pkg::MUL_DV2_E1: begin
				mul_a_w = dv2_q;
				mul_b_w = BW'(e1_q[comp_q]);
			end
			ttuv_pkg::MUL_DV1_E2: begin
				mul_a_w = dv1_q;
				mul_b_w = BW'(e2_q[comp_q]);
			end
			default: begin
				mul_a_w = du1_q;
				mul_b_w = BW'(dv2_q);
			end
		endcase
	end

	ttuv_mul #(
		.A_W(DVW),
		.B_W(BW)
	) u_mul (
		.clk(clk),
		.a(mul_a_w),
		.b(mul_b_w),
		.prod(prod_w)
	);

	// first product parks in the accumulator, the second is subtracted from it
	assign diff_w = acc_q - AW'(prod_w);
	assign det_w = $signed(diff_w[DW-1:0]);
	assign det_zero_w = (det_w == '0);
	assign num_w = diff_w[NW-1:0];
	assign num_mag_w = num_w[NW-1] ? (NW'(0) - num_w) : num_w;
	assign det_mag_w = det_q[DW-1] ? (DW'(0) - DW'(det_q)) : DW'(det_q);
	assign num_sh_w = NMW'(num_mag_w) << NS;
	assign den_sh_w = DMW'(det_mag_w) << DS;

	assign div_req.start = ctl.div_start;
	assign div_req.neg = num_w[NW-1] ^ det_q[DW-1];

	ttuv_div #(
		.NUM_W(NMW),
		.DEN_W(DMW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.num(num_sh_w),
		.den(den_sh_w),
		.rsp(div_rsp)
	);

	always_ff @(posedge clk) begin
		if (ctl.acc_load) begin
			acc_q <= AW'(prod_w);
		end
		if (ctl.det_load) begin
			det_q <= det_w;
			degen_q <= det_zero_w;
			// zero determinant: fixed tangent along z
			if (det_zero_w) begin
				tan_q[0] <= '0;
				tan_q[1] <= '0;
				tan_q[2] <= ttuv_pkg::ONE_Q16;
			end
		end
		if (state_q == ttuv_pkg::ST_DIV && div_rsp.done) begin
			tan_q[comp_q] <= div_rsp.quot;
		end
		if (ctl.out_load) begin
			tx_q <= tan_q[0];
			ty_q <= tan_q[1];
			tz_q <= tan_q[2];
			degenerate_q <= degen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign tangent_x = $signed(tx_q);
	assign tangent_y = $signed(ty_q);
	assign tangent_z = $signed(tz_q);
	assign degenerate = degenerate_q;

	a_third_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc_w && third_w |=> state_q == ttuv_pkg::ST_DET_A)
		else $error("third corner did not start the sequence");

	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc_w |-> corner_q <= ttuv_pkg::LAST_CORNER)
		else $error("corner count out of range");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ttuv_pkg::ST_DIV)
		else $error("divider result outside the divide phase");

	a_degen_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == '0 && tangent_y == '0 &&
			tangent_z == ttuv_pkg::ONE_Q16)
		else $error("degenerate beat with wrong tangent");

endmodule

FILE: design/ttuv_mul.sv
// shared signed multiplier with registered product
module ttuv_mul #(
	parameter int A_W = 17,
	parameter int B_W = 33
) (
	input logic clk,
	input logic signed [A_W-1:0] a,
	input logic signed [B_W-1:0] b,
	output logic signed [A_W+B_W-1:0] prod
);

	logic signed [A_W+B_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

	assign prod = prod_q;

endmodule

FILE: design/ttuv_div.sv
// radix-2 restoring divider, one quotient bit per cycle, saturated signed result
module ttuv_div #(
	parameter int NUM_W = 63,
	parameter int DEN_W = 35
) (
	input logic clk,
	input logic arst_n,
	input ttuv_pkg::div_req_t req,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output ttuv_pkg::div_rsp_t rsp
);

	localparam int QW = ttuv_pkg::QUOT_W;
	localparam int HI_W = NUM_W - QW;
	localparam int REM_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
	localparam int CNT_W = $clog2(QW);

	logic busy_q;
	logic fin_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic big_q;
	logic neg_q;
	logic [ttuv_pkg::OUT_W-1:0] res_q;

	logic [REM_W-1:0] hi_w;
	logic [REM_W-1:0] rem_sh_w;
	logic [REM_W:0] diff_w;
	logic take_w;
	logic [QW-1:0] mag_w;
	logic [ttuv_pkg::OUT_W-1:0] sat_w;

	assign hi_w = REM_W'(num[NUM_W-1:QW]);
	assign rem_sh_w = {rem_q[REM_W-2:0], quo_q[QW-1]};
	assign diff_w = {1'b0, rem_sh_w} - {1'b0, REM_W'(den_q)};
	assign take_w = ~diff_w[REM_W];

	// clamp to the signed 32-bit range
	always_comb begin
		if (neg_q) begin
			mag_w = (big_q || quo_q > ttuv_pkg::NEG_LIMIT) ? ttuv_pkg::NEG_LIMIT : quo_q;
			sat_w = '0 - mag_w;
		end else begin
			mag_w = (big_q || quo_q > ttuv_pkg::POS_LIMIT) ? ttuv_pkg::POS_LIMIT : quo_q;
			sat_w = mag_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// quotient overflows 32 bits when the upper numerator part reaches the divisor
			rem_q <= hi_w;
			quo_q <= num[QW-1:0];
			den_q <= den;
			big_q <= hi_w >= REM_W'(den);
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= take_w ? diff_w[REM_W-1:0] : rem_sh_w;
			quo_q <= {quo_q[QW-2:0], take_w};
		end
		if (fin_q) begin
			res_q <= sat_w;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !fin_q)
		else $error("divider started while busy");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> done_q && !busy_q)
		else $error("divider done pulse missing");

endmodule
